// ===== design/bor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bor_pkg;

  // Field widths fixed by the word format
  localparam int MACH_W  = 4;
  localparam int UTIL_W  = 16;
  localparam int THR_W   = 17;
  localparam int SUM_W   = 17;
  localparam int TOT_W   = 23;
  localparam int CNT_W   = 5;
  localparam int PLACE_MAX = 16;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd58982;

  // Input op codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;   // unused, ignored

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_REBALANCED = 2'd1;
  localparam logic [1:0] ST_UNRESOLVED = 2'd2;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_ENABLE    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN0,
    S_SCAN1,
    S_SCAN2,
    S_MARK,
    S_TEST,
    S_CAND,
    S_LIMIT,
    S_SORT,
    S_CHOOSE,
    S_SW0,
    S_SW1,
    S_SW2,
    S_SW3,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/bor_util_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Utilisation table: one write port, one registered read port.
// Entries never written since reset read as zero.
module bor_util_mem #(
  parameter int AW    = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [bor_pkg::UTIL_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [bor_pkg::UTIL_W-1:0]  rdata
);

  logic [bor_pkg::UTIL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= vld[raddr] ? mem[raddr] : '0;
  end

endmodule

`default_nettype wire

// ===== design/bandwidth_overload_rebalancer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bandwidth overload checker and rebalancer.
// Input words (s_*) set or clear one utilisation entry, or append one
// (machine, slot) pair of a job placement; s_tlast marks the final pair.
// Set, clear and non-final pair words leave the block idle and ready.
// On the final pair the block runs a check over L = min(MACHINES,16)
// machines under a sequencer: it snapshots the table, marks, tests,
// picks candidates, checks the limit, sorts descending and chooses
// slots; the test or the limit check may end the run early.
// Results go out on m_*: one word with status 0 or 2, or n words with
// status 1 (n pairs), each after the table swap for its pair.
// s_tready is low from the final pair until the last result is taken;
// a stalled receiver simply holds the block in its output state.
// Reset empties the table, clears the pair count, loads config defaults.
// The user must write configuration through cfg_we/cfg_index/cfg_data
// only when idle; the block itself does not enforce it.
module bandwidth_overload_rebalancer_unit #(
  parameter int MACHINES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // machine[3:0], slot[4], util[20:5]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // dest_machine[3:0], dest_slot[4]
  output logic      [1:0]  m_tuser,   // status[1:0]
  output logic             m_tlast,   // end_of_run
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int LIVE = (MACHINES < 16) ? MACHINES : 16;
  localparam int LW   = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam int CW   = LW + 1;
  localparam int AW   = LW + 1;

  bor_pkg::state_t state, state_next;

  // config
  logic [bor_pkg::THR_W-1:0] threshold;
  logic                      rebal_en;

  // input fields
  logic [1:0]                 in_op;
  logic [bor_pkg::MACH_W-1:0] in_mach;
  logic                       in_slot;
  logic [bor_pkg::UTIL_W-1:0] in_util;
  logic                       in_range;
  logic                       in_acc;

  // placement list
  logic [LW-1:0]             pl_m [bor_pkg::PLACE_MAX];
  logic                      pl_s [bor_pkg::PLACE_MAX];
  logic [bor_pkg::CNT_W-1:0] pcount;
  logic [bor_pkg::CNT_W-1:0] nrun;

  // per-machine snapshot
  logic [bor_pkg::SUM_W-1:0] msum [LIVE];
  logic [LIVE-1:0]           gt_f, lt_f, seen, fslot, mapped, ctaken;
  logic [LW:0]               mapc [LIVE];

  // scratch lists
  logic [LW-1:0]             marked [bor_pkg::PLACE_MAX];
  logic [LW-1:0]             mord   [bor_pkg::PLACE_MAX];
  logic [LW-1:0]             cand   [bor_pkg::PLACE_MAX];
  logic [bor_pkg::PLACE_MAX-1:0] mtaken;

  // sequencer registers
  logic [CW-1:0]             mcnt;
  logic [bor_pkg::CNT_W-1:0] j, k, r, q;
  logic [LW-1:0]             best_m;
  logic [3:0]                best_q;
  logic [bor_pkg::SUM_W-1:0] best_s;
  logic                      have;
  logic [bor_pkg::TOT_W-1:0] total;
  logic [bor_pkg::UTIL_W-1:0] ua;
  logic [LW-1:0]             nm_q;
  logic                      ns_q;

  // output register
  logic [1:0]                o_status;
  logic [LW-1:0]             o_mach;
  logic                      o_slot;
  logic                      o_last;

  // table memory port
  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [bor_pkg::UTIL_W-1:0] wdata, rdata;

  // shared comparison and working values
  logic [LW-1:0]             cur_m;
  logic                      cur_s;
  logic [bor_pkg::SUM_W-1:0] key_s;
  logic [LW-1:0]             key_m;
  logic [LW-1:0]             om, nm;
  logic                      os_c, ns_c;
  logic [21:0]               thr_k;
  logic [bor_pkg::TOT_W-1:0] limit;

  assign in_op    = s_tuser;
  assign in_mach  = s_tdata[3:0];
  assign in_slot  = s_tdata[4];
  assign in_util  = s_tdata[20:5];
  assign in_range = {1'b0, in_mach} < 5'(LIVE);
  assign s_tready = (state == bor_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign m_tvalid = (state == bor_pkg::S_OUT);
  assign m_tdata  = {3'b000, o_slot, bor_pkg::MACH_W'(o_mach)};
  assign m_tuser  = o_status;
  assign m_tlast  = o_last;

  // current placement entry
  assign cur_m = pl_m[j[3:0]];
  assign cur_s = pl_s[j[3:0]];

  // sort key of a marked position
  assign key_m = marked[q[3:0]];
  assign key_s = msum[key_m];

  // slot choice for one marked/candidate pair
  assign om   = mord[r[3:0]];
  assign nm   = cand[r[3:0]];
  assign os_c = fslot[om];
  assign ns_c = (os_c ? lt_f[om] : gt_f[om]) ? gt_f[nm] : lt_f[nm];

  // acceptance limit threshold*k*2
  assign thr_k = 22'(threshold) * 22'(k);
  assign limit = {thr_k, 1'b0};

  bor_util_mem #(
    .AW    (AW),
    .DEPTH (LIVE * 2)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= bor_pkg::THRESHOLD_RESET;
      rebal_en  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bor_pkg::REG_THRESHOLD: threshold <= cfg_data;
        bor_pkg::REG_ENABLE:    rebal_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bor_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and table port control
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      bor_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((in_op == bor_pkg::OP_SET || in_op == bor_pkg::OP_CLEAR) && in_range) begin
            we    = 1'b1;
            waddr = {in_mach[LW-1:0], in_slot};
            wdata = (in_op == bor_pkg::OP_SET) ? in_util : '0;
          end
          if (in_op == bor_pkg::OP_PLACE && s_tlast) begin
            state_next = bor_pkg::S_SCAN0;
          end
        end
      end
      bor_pkg::S_SCAN0: begin
        raddr      = {mcnt[LW-1:0], 1'b0};
        state_next = bor_pkg::S_SCAN1;
      end
      bor_pkg::S_SCAN1: begin
        raddr      = {mcnt[LW-1:0], 1'b1};
        state_next = bor_pkg::S_SCAN2;
      end
      bor_pkg::S_SCAN2: begin
        state_next = (mcnt == CW'(LIVE - 1)) ? bor_pkg::S_MARK : bor_pkg::S_SCAN0;
      end
      bor_pkg::S_MARK: begin
        if (j == nrun) begin
          state_next = bor_pkg::S_TEST;
        end
      end
      bor_pkg::S_TEST: begin
        if (k == '0 || !rebal_en || k > 5'(LIVE)) begin
          state_next = bor_pkg::S_OUT;
        end else begin
          state_next = bor_pkg::S_CAND;
        end
      end
      bor_pkg::S_CAND: begin
        if (mcnt == CW'(LIVE) && r + 5'd1 == k) begin
          state_next = bor_pkg::S_LIMIT;
        end
      end
      bor_pkg::S_LIMIT: begin
        state_next = (total >= limit) ? bor_pkg::S_OUT : bor_pkg::S_SORT;
      end
      bor_pkg::S_SORT: begin
        if (q == k && r + 5'd1 == k) begin
          state_next = bor_pkg::S_CHOOSE;
        end
      end
      bor_pkg::S_CHOOSE: begin
        if (r + 5'd1 == k) begin
          state_next = bor_pkg::S_SW0;
        end
      end
      bor_pkg::S_SW0: begin
        raddr      = {cur_m, cur_s};
        state_next = bor_pkg::S_SW1;
      end
      bor_pkg::S_SW1: begin
        raddr      = {nm_q, ns_q};
        state_next = bor_pkg::S_SW2;
      end
      bor_pkg::S_SW2: begin
        we         = 1'b1;
        waddr      = {cur_m, cur_s};
        wdata      = rdata;
        state_next = bor_pkg::S_SW3;
      end
      bor_pkg::S_SW3: begin
        we         = 1'b1;
        waddr      = {nm_q, ns_q};
        wdata      = ua;
        state_next = bor_pkg::S_OUT;
      end
      bor_pkg::S_OUT: begin
        if (m_tready) begin
          state_next = o_last ? bor_pkg::S_IDLE : bor_pkg::S_SW0;
        end
      end
      default: state_next = bor_pkg::S_IDLE;
    endcase
  end

  // placement count
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
    end else if (in_acc && in_op == bor_pkg::OP_PLACE) begin
      if (s_tlast) begin
        pcount <= '0;
      end else if (in_range && pcount < 5'(bor_pkg::PLACE_MAX)) begin
        pcount <= pcount + 5'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bor_pkg::S_IDLE: begin
        if (in_acc && in_op == bor_pkg::OP_PLACE) begin
          if (in_range && pcount < 5'(bor_pkg::PLACE_MAX)) begin
            pl_m[pcount[3:0]] <= in_mach[LW-1:0];
            pl_s[pcount[3:0]] <= in_slot;
          end
          // start of a check: clear per-run flags
          nrun   <= (in_range && pcount < 5'(bor_pkg::PLACE_MAX)) ? pcount + 5'd1 : pcount;
          mcnt   <= '0;
          j      <= '0;
          k      <= '0;
          total  <= '0;
          seen   <= '0;
          mapped <= '0;
          ctaken <= '0;
          mtaken <= '0;
        end
      end
      bor_pkg::S_SCAN1: begin
        ua <= rdata;
      end
      bor_pkg::S_SCAN2: begin
        // two-slot sum and slot order of one machine
        msum[mcnt[LW-1:0]] <= {1'b0, ua} + {1'b0, rdata};
        gt_f[mcnt[LW-1:0]] <= rdata > ua;
        lt_f[mcnt[LW-1:0]] <= rdata < ua;
        mcnt <= mcnt + CW'(1);
      end
      bor_pkg::S_MARK: begin
        if (j != nrun) begin
          if (!seen[cur_m]) begin
            seen[cur_m]  <= 1'b1;
            fslot[cur_m] <= cur_s;
          end
          if (msum[cur_m] > threshold) begin
            marked[k[3:0]] <= cur_m;
            k     <= k + 5'd1;
            total <= total + bor_pkg::TOT_W'(msum[cur_m]);
          end
          j <= j + 5'd1;
        end
      end
      bor_pkg::S_TEST: begin
        o_mach <= '0;
        o_slot <= 1'b0;
        o_last <= 1'b1;
        o_status <= (k == '0) ? bor_pkg::ST_OK : bor_pkg::ST_UNRESOLVED;
        r    <= '0;
        mcnt <= '0;
        have <= 1'b0;
      end
      bor_pkg::S_CAND: begin
        // lowest-sum untaken machine, lower index on ties
        if (mcnt == CW'(LIVE)) begin
          cand[r[3:0]]   <= best_m;
          ctaken[best_m] <= 1'b1;
          total <= total + bor_pkg::TOT_W'(best_s);
          r     <= r + 5'd1;
          mcnt  <= '0;
          have  <= 1'b0;
        end else begin
          if (!ctaken[mcnt[LW-1:0]] && (!have || msum[mcnt[LW-1:0]] < best_s)) begin
            best_m <= mcnt[LW-1:0];
            best_s <= msum[mcnt[LW-1:0]];
            have   <= 1'b1;
          end
          mcnt <= mcnt + CW'(1);
        end
      end
      bor_pkg::S_LIMIT: begin
        o_status <= bor_pkg::ST_UNRESOLVED;
        r    <= '0;
        q    <= '0;
        have <= 1'b0;
      end
      bor_pkg::S_SORT: begin
        // highest-sum marked entry, earlier entry on ties
        if (q == k) begin
          mord[r[3:0]]   <= best_m;
          mtaken[best_q] <= 1'b1;
          q    <= '0;
          have <= 1'b0;
          r    <= (r + 5'd1 == k) ? '0 : r + 5'd1;
        end else begin
          if (!mtaken[q[3:0]] && (!have || key_s > best_s)) begin
            best_m <= key_m;
            best_q <= q[3:0];
            best_s <= key_s;
            have   <= 1'b1;
          end
          q <= q + 5'd1;
        end
      end
      bor_pkg::S_CHOOSE: begin
        if (!mapped[om]) begin
          mapped[om] <= 1'b1;
          mapc[om]   <= {nm, ns_c};
        end
        r <= r + 5'd1;
        j <= '0;
      end
      bor_pkg::S_SW0: begin
        if (mapped[cur_m]) begin
          {nm_q, ns_q} <= mapc[cur_m];
        end else begin
          nm_q <= cur_m;
          ns_q <= cur_s;
        end
      end
      bor_pkg::S_SW1: begin
        ua <= rdata;
      end
      bor_pkg::S_SW3: begin
        o_status <= bor_pkg::ST_REBALANCED;
        o_mach   <= nm_q;
        o_slot   <= ns_q;
        o_last   <= (j + 5'd1 == nrun);
      end
      bor_pkg::S_OUT: begin
        if (m_tready) begin
          j <= j + 5'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
